FILE: rtl/wpns_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the pose search core.
// No dependencies.
package wpns_pkg;

  localparam int MAX_POSES_DEF    = 64;
  localparam int CORDIC_STEPS_DEF = 14;

  localparam int IDX_W = 6;
  localparam int XY_W  = 16;
  localparam int HD_W  = 15;
  localparam int WT_W  = 16;
  localparam int CX_W  = 28;   // CORDIC x/y datapath
  localparam int CZ_W  = 20;   // CORDIC angle, Q.16 radians
  localparam int DSQ_W = 35;   // dx^2 + dy^2, unsigned integer (Q35.0)
  localparam int DIST_W = 40;
  localparam int SQ_W  = 38;   // (b*w)^2 >> 24

  localparam int HALF_PI_Q16 = 102944;
  localparam int PI_Q12      = 12868;
  localparam int TWO_PI_Q12  = 25736;

  localparam logic [WT_W-1:0] ANGLE_WEIGHT_RST = 16'd256;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_NEAREST = 2'd2,
    CMD_RADIUS  = 2'd3
  } cmd_e;

  // per-slot tag that rides alongside the datapath
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [IDX_W-1:0]        idx;
    logic                    zero;
    logic signed [HD_W-1:0]  heading;
    logic [DSQ_W-1:0]        dsq;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [CZ_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             found;
    logic             full;
    logic             last;
  } result_t;

  function automatic logic signed [CZ_W-1:0] atan_q16(input int i);
    logic signed [CZ_W-1:0] a;
    case (i)
      0:  a = 20'sd51472;
      1:  a = 20'sd30385;
      2:  a = 20'sd16055;
      3:  a = 20'sd8150;
      4:  a = 20'sd4091;
      5:  a = 20'sd2047;
      6:  a = 20'sd1024;
      7:  a = 20'sd512;
      8:  a = 20'sd256;
      9:  a = 20'sd128;
      10: a = 20'sd64;
      11: a = 20'sd32;
      12: a = 20'sd16;
      13: a = 20'sd8;
      14: a = 20'sd4;
      15: a = 20'sd2;
      16: a = 20'sd1;
      17: a = 20'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/wpns_in_if.sv
// Input item channel: command and pose / query fields.
// Depends on nothing.
interface wpns_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [14:0] heading;
  logic signed [15:0] radius;
  modport source (output valid, command, pos_x, pos_y, heading, radius, input ready);
  modport sink   (input valid, command, pos_x, pos_y, heading, radius, output ready);
endinterface

FILE: rtl/wpns_out_if.sv
// Result item channel.
// Depends on nothing.
interface wpns_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] index;
  logic       found;
  logic       store_full;
  logic       last;
  modport source (output valid, index, found, store_full, last, input ready);
  modport sink   (input valid, index, found, store_full, last, output ready);
endinterface

FILE: rtl/wpns_cfg_if.sv
// Configuration write channel carrying the angle weight.
// Depends on nothing.
interface wpns_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/wpns_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module wpns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: rtl/wpns_cordic_cell.sv
// One CORDIC vectoring step; cells are chained, each handing its result on every cycle that en_i is high.
// Depends on wpns_pkg.
module wpns_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  wpns_pkg::cordic_t cell_i,
  output wpns_pkg::cordic_t cell_o
);
  wpns_pkg::cordic_t cell_d, cell_q;
  logic signed [wpns_pkg::CX_W-1:0] xs, ys;

  always_comb begin
    xs = cell_i.x >>> STEP;
    ys = cell_i.y >>> STEP;
    cell_d = cell_i;
    if (cell_i.y >= 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + wpns_pkg::atan_q16(STEP);
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - wpns_pkg::atan_q16(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

FILE: rtl/weighted_pose_neighbor_search_core.sv
// Top level of the weighted pose neighbor search; holds the pose RAM, control FSM and datapath.
// Depends on wpns_pkg, the wpns_*_if interfaces, wpns_ram and wpns_cordic_cell.

// Stores up to MAX_POSES planar poses and answers nearest and radius queries by
// streaming every stored pose, one per cycle, through a pipelined distance unit:
// RAM read, difference, pre-rotation, a chain of CORDIC_STEPS vectoring cells,
// then bearing wrap, weight multiply, square and sum. Clear and append bypass the
// pipeline. The single RAM read port feeds the pipeline. A radius query whose
// last pose matches while an earlier match is pending ends through a flush
// state. The whole pipeline holds while a result waits on the output register.
// New items are taken only after a query has finished.
module weighted_pose_neighbor_search_core #(
  parameter int MAX_POSES    = wpns_pkg::MAX_POSES_DEF,
  parameter int CORDIC_STEPS = wpns_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpns_cfg_if.sink    cfg_i,
  wpns_in_if.sink     in_i,
  wpns_out_if.source  out_o
);
  localparam int AW    = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
  localparam int CNT_W = $clog2(MAX_POSES + 1);
  localparam int RW    = 2 * wpns_pkg::XY_W + wpns_pkg::HD_W;
  localparam int DX_W  = wpns_pkg::XY_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d, issue_q, issue_d;
  logic [wpns_pkg::WT_W-1:0] weight_q;
  logic rad_q, rad_d;
  logic signed [wpns_pkg::XY_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [31:0] lim_q, lim_d;
  logic have_q, have_d, pend_q, pend_d;
  logic [wpns_pkg::DIST_W-1:0] best_q, best_d;
  logic [wpns_pkg::IDX_W-1:0] bidx_q, bidx_d, pidx_q, pidx_d;
  logic out_v_q, out_v_d;
  wpns_pkg::result_t out_q, out_d;

  logic adv, accept, we;
  logic [RW-1:0] rdata;
  logic s0_v_q, s0_v_d, s0_last_q, s0_last_d;
  logic [wpns_pkg::IDX_W-1:0] s0_idx_q, s0_idx_d;

  // stage B: differences
  wpns_pkg::side_t sb_q, sb_d;
  logic signed [DX_W-1:0] dx_q, dy_q, dx_d, dy_d;
  // stage C: pre-rotated CORDIC input
  wpns_pkg::cordic_t c0_q, c0_d;
  wpns_pkg::cordic_t chain [CORDIC_STEPS+1];
  logic signed [2*DX_W-1:0] sqx, sqy;

  // post stages
  wpns_pkg::side_t p1_q, p2_q, p3_q, p4_q;
  logic signed [wpns_pkg::CZ_W-1:0] zr;
  logic signed [16:0] b0, b1, b2;
  logic signed [15:0] p1_b_q, p1_b_d;
  logic signed [32:0] p2_t_q;
  logic signed [65:0] sq;
  logic [wpns_pkg::SQ_W-1:0] p3_s_q;
  logic [wpns_pkg::DIST_W-1:0] p4_d_q;
  logic match, better;

  assign adv         = !out_v_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && adv;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign we = accept && (wpns_pkg::cmd_e'(in_i.command) == wpns_pkg::CMD_APPEND) &&
              (count_q < CNT_W'(MAX_POSES));

  wpns_ram #(.WIDTH(RW), .DEPTH(MAX_POSES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_i.pos_x, in_i.pos_y, in_i.heading}),
    .re_i    (adv),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // issue and front-end stages
  always_comb begin
    s0_v_d    = (state_q == S_RUN) && (issue_q < count_q);
    s0_last_d = (issue_q == count_q - CNT_W'(1));
    s0_idx_d  = wpns_pkg::IDX_W'(issue_q);

    sb_d = '0;
    sb_d.valid   = s0_v_q;
    sb_d.last    = s0_last_q;
    sb_d.idx     = s0_idx_q;
    sb_d.heading = rdata[wpns_pkg::HD_W-1:0];
    dx_d = DX_W'(qx_q) - DX_W'($signed(rdata[RW-1 -: wpns_pkg::XY_W]));
    dy_d = DX_W'(qy_q) - DX_W'($signed(rdata[wpns_pkg::HD_W +: wpns_pkg::XY_W]));

    sqx = dx_q * dx_q;
    sqy = dy_q * dy_q;
    c0_d = '0;
    c0_d.side      = sb_q;
    c0_d.side.zero = (dx_q == '0) && (dy_q == '0);
    c0_d.side.dsq  = wpns_pkg::DSQ_W'($unsigned(sqx)) + wpns_pkg::DSQ_W'($unsigned(sqy));
    c0_d.x = wpns_pkg::CX_W'(dx_q) <<< 8;
    c0_d.y = wpns_pkg::CX_W'(dy_q) <<< 8;
    c0_d.z = '0;
    if (c0_d.x < 0) begin
      if (c0_d.y >= 0) begin
        c0_d.x = wpns_pkg::CX_W'(dy_q) <<< 8;
        c0_d.y = -(wpns_pkg::CX_W'(dx_q) <<< 8);
        c0_d.z = wpns_pkg::CZ_W'(wpns_pkg::HALF_PI_Q16);
      end else begin
        c0_d.x = -(wpns_pkg::CX_W'(dy_q) <<< 8);
        c0_d.y = wpns_pkg::CX_W'(dx_q) <<< 8;
        c0_d.z = -wpns_pkg::CZ_W'(wpns_pkg::HALF_PI_Q16);
      end
    end
  end

  assign chain[0] = c0_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    wpns_cordic_cell #(.STEP(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // bearing: round to Q3.12, subtract heading, wrap by whole turns
  always_comb begin
    zr = chain[CORDIC_STEPS].z + wpns_pkg::CZ_W'(8);
    b0 = 17'(zr >>> 4) - 17'(chain[CORDIC_STEPS].side.heading);
    b1 = b0;
    if (b0 >= 17'(wpns_pkg::PI_Q12)) begin
      b1 = b0 - 17'(wpns_pkg::TWO_PI_Q12);
    end else if (b0 < -17'(wpns_pkg::PI_Q12)) begin
      b1 = b0 + 17'(wpns_pkg::TWO_PI_Q12);
    end
    b2 = b1;
    if (b1 >= 17'(wpns_pkg::PI_Q12)) begin
      b2 = b1 - 17'(wpns_pkg::TWO_PI_Q12);
    end else if (b1 < -17'(wpns_pkg::PI_Q12)) begin
      b2 = b1 + 17'(wpns_pkg::TWO_PI_Q12);
    end
    p1_b_d = chain[CORDIC_STEPS].side.zero ? '0 : 16'(b2);
    sq = p2_t_q * p2_t_q;
  end

  assign match  = p4_d_q < wpns_pkg::DIST_W'(lim_q);
  assign better = !have_q || (p4_d_q < best_q);

  // control
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    issue_d = issue_q;
    rad_d   = rad_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    lim_d   = lim_q;
    have_d  = have_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    pend_d  = pend_q;
    pidx_d  = pidx_q;
    out_v_d = out_v_q && !out_o.ready;
    out_d   = out_q;

    if (accept) begin
      case (wpns_pkg::cmd_e'(in_i.command))
        wpns_pkg::CMD_CLEAR: begin
          count_d = '0;
          out_v_d = 1'b1;
          out_d   = '{idx: '0, found: 1'b0, full: 1'b0, last: 1'b1};
        end
        wpns_pkg::CMD_APPEND: begin
          out_v_d = 1'b1;
          if (count_q >= CNT_W'(MAX_POSES)) begin
            out_d = '{idx: '0, found: 1'b0, full: 1'b1, last: 1'b1};
          end else begin
            out_d   = '{idx: wpns_pkg::IDX_W'(count_q), found: 1'b1, full: 1'b0, last: 1'b1};
            count_d = count_q + CNT_W'(1);
          end
        end
        wpns_pkg::CMD_NEAREST, wpns_pkg::CMD_RADIUS: begin
          rad_d   = (wpns_pkg::cmd_e'(in_i.command) == wpns_pkg::CMD_RADIUS);
          qx_d    = in_i.pos_x;
          qy_d    = in_i.pos_y;
          lim_d   = 32'($unsigned(32'(in_i.radius) * 32'(in_i.radius)));
          issue_d = '0;
          have_d  = 1'b0;
          pend_d  = 1'b0;
          if (count_q == '0 || (rad_d && in_i.radius < 0)) begin
            out_v_d = 1'b1;
            out_d   = '{idx: '0, found: 1'b0, full: 1'b0, last: 1'b1};
          end else begin
            state_d = S_RUN;
          end
        end
        default: ;
      endcase
    end

    if (state_q == S_RUN && adv) begin
      if (s0_v_d) begin
        issue_d = issue_q + CNT_W'(1);
      end
      if (p4_q.valid) begin
        if (!rad_q) begin
          if (better) begin
            have_d = 1'b1;
            best_d = p4_d_q;
            bidx_d = p4_q.idx;
          end
          if (p4_q.last) begin
            out_v_d = 1'b1;
            out_d   = '{idx: better ? p4_q.idx : bidx_q, found: 1'b1, full: 1'b0, last: 1'b1};
            state_d = S_IDLE;
          end
        end else begin
          if (match) begin
            pend_d = 1'b1;
            pidx_d = p4_q.idx;
            if (pend_q) begin
              out_v_d = 1'b1;
              out_d   = '{idx: pidx_q, found: 1'b1, full: 1'b0, last: 1'b0};
            end
          end
          if (p4_q.last) begin
            if (match && pend_q) begin
              state_d = S_FLUSH;
            end else if (match) begin
              out_v_d = 1'b1;
              out_d   = '{idx: p4_q.idx, found: 1'b1, full: 1'b0, last: 1'b1};
              state_d = S_IDLE;
            end else if (pend_q) begin
              out_v_d = 1'b1;
              out_d   = '{idx: pidx_q, found: 1'b1, full: 1'b0, last: 1'b1};
              state_d = S_IDLE;
            end else begin
              out_v_d = 1'b1;
              out_d   = '{idx: '0, found: 1'b0, full: 1'b0, last: 1'b1};
              state_d = S_IDLE;
            end
          end
        end
      end
    end

    if (state_q == S_FLUSH && adv) begin
      out_v_d = 1'b1;
      out_d   = '{idx: pidx_q, found: 1'b1, full: 1'b0, last: 1'b1};
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      weight_q  <= wpns_pkg::ANGLE_WEIGHT_RST;
      out_v_q   <= 1'b0;
      issue_q   <= '0;
      rad_q     <= 1'b0;
      qx_q      <= '0;
      qy_q      <= '0;
      lim_q     <= '0;
      have_q    <= 1'b0;
      best_q    <= '0;
      bidx_q    <= '0;
      pend_q    <= 1'b0;
      pidx_q    <= '0;
      out_q     <= '0;
      s0_v_q    <= 1'b0;
      s0_last_q <= 1'b0;
      s0_idx_q  <= '0;
      sb_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      c0_q      <= '0;
      p1_q      <= '0;
      p2_q      <= '0;
      p3_q      <= '0;
      p4_q      <= '0;
      p1_b_q    <= '0;
      p2_t_q    <= '0;
      p3_s_q    <= '0;
      p4_d_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
      issue_q <= issue_d;
      rad_q   <= rad_d;
      qx_q    <= qx_d;
      qy_q    <= qy_d;
      lim_q   <= lim_d;
      have_q  <= have_d;
      best_q  <= best_d;
      bidx_q  <= bidx_d;
      pend_q  <= pend_d;
      pidx_q  <= pidx_d;
      out_q   <= out_d;
      if (cfg_i.valid && cfg_i.ready) begin
        weight_q <= cfg_i.data;
      end
      if (adv) begin
        s0_v_q    <= s0_v_d;
        s0_last_q <= s0_last_d;
        s0_idx_q  <= s0_idx_d;
        sb_q      <= sb_d;
        dx_q      <= dx_d;
        dy_q      <= dy_d;
        c0_q      <= c0_d;
        p1_q      <= chain[CORDIC_STEPS].side;
        p1_b_q    <= p1_b_d;
        p2_q      <= p1_q;
        p2_t_q    <= p1_b_q * $signed({1'b0, weight_q});
        p3_q      <= p2_q;
        p3_s_q    <= sq[wpns_pkg::SQ_W+23:24];
        p4_q      <= p3_q;
        p4_d_q    <= wpns_pkg::DIST_W'(p3_s_q) + wpns_pkg::DIST_W'(p3_q.dsq);
      end
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.index      = out_q.idx;
  assign out_o.found      = out_q.found;
  assign out_o.store_full = out_q.full;
  assign out_o.last       = out_q.last;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POSES))
    else $error("pose count beyond store depth");

  a_found_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.found |-> CNT_W'(out_q.idx) < count_q)
    else $error("found index outside stored poses");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.full |-> count_q == CNT_W'(MAX_POSES) && !out_q.found)
    else $error("store_full reported with room left");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !p4_q.valid && !s0_v_q)
    else $error("pipeline busy while idle");
`endif

endmodule

FILE: tb/tb.sv
// Testbench for weighted_pose_neighbor_search_core: random and directed pose commands,
// with a built-in predictor of all four commands checking every result.
// Depends on wpns_pkg, the wpns_*_if interfaces and the core RTL.
`timescale 1ns / 100ps

module tb;

  typedef struct {
    wpns_pkg::cmd_e     command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [14:0] heading;
    logic signed [15:0] radius;
  } pose_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wpns_cfg_if cfg_ch();
  wpns_in_if  in_ch();
  wpns_out_if out_ch();

  weighted_pose_neighbor_search_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  int        pose_x   [64];
  int        pose_y   [64];
  int        pose_hd  [64];
  int        pose_cnt;
  int        weight_q = 256;

  pose_cmd_t         cmd_backlog[$];
  wpns_pkg::result_t expected_hits[$];
  pose_cmd_t         offered;
  int                errors = 0;

  function automatic void queue_result(wpns_pkg::result_t r);
    expected_hits.insert(expected_hits.size(), r);
  endfunction

  function automatic void queue_cmd(pose_cmd_t p);
    cmd_backlog.insert(cmd_backlog.size(), p);
  endfunction

  // world angle of (dx, dy) in Q3.12, vectoring on a Q.16 angle accumulator
  function automatic int cordic_angle(int dx, int dy);
    longint x, y, z, t, xs, ys;
    longint atan_tab [20] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                              64, 32, 16, 8, 4, 2, 1, 1, 0, 0};
    x = longint'(dx) * 256;
    y = longint'(dy) * 256;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = wpns_pkg::HALF_PI_Q16;
      end else begin
        t = x; x = -y; y = t; z = -wpns_pkg::HALF_PI_Q16;
      end
    end
    for (int i = 0; i < wpns_pkg::CORDIC_STEPS_DEF && i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_tab[i];
      end
    end
    return int'((z + 8) >>> 4);
  endfunction

  function automatic longint unsigned weighted_dist(int slot, int qx, int qy);
    int                dx, dy, b;
    longint            t;
    longint unsigned   d, sq;
    dx = qx - pose_x[slot];
    dy = qy - pose_y[slot];
    b = 0;
    if (dx != 0 || dy != 0) begin
      b = cordic_angle(dx, dy) - pose_hd[slot];
      for (int k = 0; k < 2; k++) begin
        if (b >= wpns_pkg::PI_Q12) b -= wpns_pkg::TWO_PI_Q12;
        else if (b < -wpns_pkg::PI_Q12) b += wpns_pkg::TWO_PI_Q12;
      end
    end
    d = longint'(dx) * dx + longint'(dy) * dy;
    t = longint'(b) * weight_q;
    sq = t * t;
    d += sq >> 24;
    if (d > 64'hFF_FFFF_FFFF) d = 64'hFF_FFFF_FFFF;
    return d;
  endfunction

  function automatic wpns_pkg::result_t mk_res(int idx, bit fnd, bit full, bit lst);
    wpns_pkg::result_t r;
    r.idx = idx[5:0]; r.found = fnd; r.full = full; r.last = lst;
    return r;
  endfunction

  task automatic predict_search(pose_cmd_t c);
    longint unsigned best, d, lim;
    int              bi, hits;
    bit              have;
    case (c.command)
      wpns_pkg::CMD_CLEAR: begin
        pose_cnt = 0;
        queue_result(mk_res(0, 0, 0, 1));
      end
      wpns_pkg::CMD_APPEND: begin
        if (pose_cnt >= wpns_pkg::MAX_POSES_DEF) begin
          queue_result(mk_res(0, 0, 1, 1));
        end else begin
          pose_x[pose_cnt] = int'(c.pos_x);
          pose_y[pose_cnt] = int'(c.pos_y);
          pose_hd[pose_cnt] = int'(c.heading);
          queue_result(mk_res(pose_cnt, 1, 0, 1));
          pose_cnt++;
        end
      end
      wpns_pkg::CMD_NEAREST: begin
        have = 0; best = 0; bi = 0;
        for (int i = 0; i < pose_cnt; i++) begin
          d = weighted_dist(i, c.pos_x, c.pos_y);
          if (!have || d < best) begin
            have = 1; best = d; bi = i;
          end
        end
        queue_result(mk_res(have ? bi : 0, have, 0, 1));
      end
      default: begin
        hits = 0;
        if (c.radius >= 0) begin
          lim = longint'(c.radius) * c.radius;
          for (int i = 0; i < pose_cnt; i++) begin
            if (weighted_dist(i, c.pos_x, c.pos_y) < lim) begin
              queue_result(mk_res(i, 1, 0, 0));
              hits++;
            end
          end
        end
        if (hits == 0) queue_result(mk_res(0, 0, 0, 1));
        else expected_hits[expected_hits.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // sender: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= wpns_pkg::CMD_CLEAR;
      in_ch.pos_x <= '0;
      in_ch.pos_y <= '0;
      in_ch.heading <= '0;
      in_ch.radius <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_search(offered);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          offered = cmd_backlog.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= offered.command;
          in_ch.pos_x <= offered.pos_x;
          in_ch.pos_y <= offered.pos_y;
          in_ch.heading <= offered.heading;
          in_ch.radius <= offered.radius;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready with a stall pattern re-drawn by mode_cnt; long hold on request
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_cnt = 0;
  int ready_pct = 100;
  wpns_pkg::result_t got;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result item: index %0d found %0b", out_ch.index, out_ch.found);
          errors++;
        end else begin
          got = expected_hits.pop_front();
          if (out_ch.index !== got.idx) begin
            $error("index: expected %0d actual %0d", got.idx, out_ch.index); errors++;
          end
          if (out_ch.found !== got.found) begin
            $error("found: expected %0b actual %0b", got.found, out_ch.found); errors++;
          end
          if (out_ch.store_full !== got.full) begin
            $error("store_full: expected %0b actual %0b", got.full, out_ch.store_full);
            errors++;
          end
          if (out_ch.last !== got.last) begin
            $error("last: expected %0b actual %0b", got.last, out_ch.last); errors++;
          end
        end
      end
      mode_cnt++;
      if (mode_cnt >= 200) begin
        mode_cnt = 0;
        case ($urandom_range(0, 2))
          0: ready_pct = 100;
          1: ready_pct = 50;
          default: ready_pct = 15;
        endcase
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  function automatic pose_cmd_t mk_cmd(wpns_pkg::cmd_e c, int x, int y, int h, int r);
    pose_cmd_t p;
    p.command = c; p.pos_x = 16'(x); p.pos_y = 16'(y); p.heading = 15'(h);
    p.radius = 16'(r);
    return p;
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom())));
  endfunction

  function automatic pose_cmd_t random_cmd(int cx, int cy);
    pose_cmd_t p;
    int        sel;
    sel = $urandom_range(0, 99);
    p.command = (sel < 2) ? wpns_pkg::CMD_CLEAR : (sel < 45) ? wpns_pkg::CMD_APPEND :
                (sel < 70) ? wpns_pkg::CMD_NEAREST : wpns_pkg::CMD_RADIUS;
    // mostly a local cluster so radius queries get hits, sometimes anywhere
    if ($urandom_range(0, 4) == 0) begin
      p.pos_x = 16'(rnd16()); p.pos_y = 16'(rnd16());
    end else begin
      p.pos_x = 16'(cx + int'($urandom_range(0, 2048)) - 1024);
      p.pos_y = 16'(cy + int'($urandom_range(0, 2048)) - 1024);
    end
    p.heading = ($urandom_range(0, 5) == 0) ? 15'($urandom())
                                             : 15'(int'($urandom_range(0, 25736)) - 12868);
    case ($urandom_range(0, 5))
      0: p.radius = 16'(rnd16());
      1: p.radius = 16'($urandom_range(0, 32767));
      default: p.radius = 16'($urandom_range(0, 1200));
    endcase
    return p;
  endfunction

  task automatic wait_idle();
    while (cmd_backlog.size() > 0 || in_ch.valid || expected_hits.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [15:0] w);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    forever begin
      @(posedge clk_i);
      if (cfg_ch.valid && cfg_ch.ready) break;
    end
    cfg_ch.valid <= 1'b0;
    weight_q = int'(w);
  endtask

  initial begin
    logic [15:0] weights [5];
    int          cx, cy;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    weights = '{16'd256, 16'd0, 16'd65535, 16'd40, 16'd1000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, extremes, coincident point, radius corners
    queue_cmd(mk_cmd(wpns_pkg::CMD_NEAREST, 0, 0, 0, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, 0, 0, 0, 32767));
    queue_cmd(mk_cmd(wpns_pkg::CMD_APPEND, -32768, 32767, 16383, -1));
    queue_cmd(mk_cmd(wpns_pkg::CMD_APPEND, 32767, -32768, -16384, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_APPEND, 100, 200, 12868, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_APPEND, -300, 50, -12868, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_NEAREST, 100, 200, 5555, -32768));
    queue_cmd(mk_cmd(wpns_pkg::CMD_NEAREST, 32767, 32767, 0, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_NEAREST, -32768, -32768, -16384, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, 100, 200, 0, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, 100, 200, 0, -1));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, 100, 200, 0, -32768));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, 0, 0, 16383, 32767));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, -300, 51, 0, 600));
    queue_cmd(mk_cmd(wpns_pkg::CMD_CLEAR, 1234, -1234, 77, 99));
    queue_cmd(mk_cmd(wpns_pkg::CMD_NEAREST, 100, 200, 0, 0));
    queue_cmd(mk_cmd(wpns_pkg::CMD_RADIUS, 100, 200, 0, 1000));
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_weight(weights[ph]);
      cx = rnd16() / 2;
      cy = rnd16() / 2;
      // a fill phase pushes the store past full
      if (ph == 1)
        for (int i = 0; i < 70; i++)
          queue_cmd(mk_cmd(wpns_pkg::CMD_APPEND, cx + int'($urandom_range(0, 600)) - 300,
                           cy + int'($urandom_range(0, 600)) - 300,
                           int'($urandom_range(0, 25736)) - 12868, 0));
      for (int i = 0; i < 65; i++) queue_cmd(random_cmd(cx, cy));
      if (ph == 2) begin
        @(posedge clk_i);
        hold_req <= hold_req + 1;
      end
      wait_idle();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: weighted_pose_neighbor_search_core.f
rtl/wpns_pkg.sv
rtl/wpns_in_if.sv
rtl/wpns_out_if.sv
rtl/wpns_cfg_if.sv
rtl/wpns_ram.sv
rtl/wpns_cordic_cell.sv
rtl/weighted_pose_neighbor_search_core.sv
tb/tb.sv
